// ===== rtl/hht_pkg.sv =====
// ----------------------------------------------------------------------------
// HTTP header tokenizer package
// Shared types, character constants and helpers for the tokenizer blocks.
// ----------------------------------------------------------------------------
package hht_pkg;

    // Character codes the tokenizer reacts to.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // Request codes.
    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    // Token kinds.
    typedef enum logic [2:0] {
        K_METHOD   = 3'd0,
        K_URL      = 3'd1,
        K_PROTO    = 3'd2,
        K_KEY      = 3'd3,
        K_VALUE    = 3'd4,
        K_LINE_END = 3'd5,
        K_HDR_END  = 3'd6
    } t_kind;

    // Tokenizer phases.
    typedef enum logic [3:0] {
        P_RL_SKIP0 = 4'd0,
        P_METHOD   = 4'd1,
        P_RL_SKIP1 = 4'd2,
        P_URL      = 4'd3,
        P_RL_SKIP2 = 4'd4,
        P_PROTO    = 4'd5,
        P_RL_TAIL  = 4'd6,
        P_AT_SKIP  = 4'd7,
        P_KEY      = 4'd8,
        P_AT_VSKIP = 4'd9,
        P_VALUE    = 4'd10
    } t_phase;

    // One result token.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic        keep;
        logic        last;
    } t_res;

    // Results of one byte, handed from the core to the output queue.
    typedef struct packed {
        logic [1:0]  cnt;
        t_res        res0;
        t_res        res1;
    } t_push;

    // Whitespace is space, TAB, LF, VT, FF and CR.
    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SP) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    // Builds one result token with the last flag clear.
    function automatic t_res mk_res(input t_kind kind, input logic [7:0] data,
                                    input logic keep);
        t_res r;
        r.kind = kind;
        r.data = data;
        r.keep = keep;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/hht_if.sv =====
// ----------------------------------------------------------------------------
// HTTP header tokenizer channels
// Valid/ready channels for header byte requests and result tokens.
// ----------------------------------------------------------------------------
interface hht_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  byte_in;

    modport source (output valid, output action, output byte_in, input ready);
    modport sink   (input valid, input action, input byte_in, output ready);
endinterface

interface hht_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  data;
    logic        keep;
    logic        last;

    modport source (output valid, output kind, output data, output keep,
                    output last, input ready);
    modport sink   (input valid, input kind, input data, input keep,
                    input last, output ready);
endinterface

// ===== rtl/http_header_tokenizer.sv =====
// A header byte's first token passes the input register, then the output queue.
// Throughput: one byte per cycle while the result channel takes a token each
// cycle. A byte with two tokens fills the two-slot output queue, so a following
// two-token byte waits until both fit; a stalled result channel holds requests.
// Reset: synchronous, active low; clears the tokenizer state to the start of
// a request line and empties the input register and output queue.
// ----------------------------------------------------------------------------
// HTTP header tokenizer
// Turns a stream of header bytes into tagged method, url, protocol, key and
// value tokens with line-end and header-end markers.
// ----------------------------------------------------------------------------
module http_header_tokenizer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hht_in_if.sink    i_req,
    hht_out_if.source o_tok
);
    import hht_pkg::*;

    t_push       push;
    logic [1:0]  free;

    // Per-byte tokenizer.
    hht_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_free  (free),
        .o_push  (push)
    );

    // Result token queue.
    hht_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_free  (free),
        .o_tok   (o_tok)
    );

endmodule

// ===== rtl/hht_core.sv =====
// ----------------------------------------------------------------------------
// HTTP header tokenizer core
// Input register, tokenizer state and the per-byte step logic.
// ----------------------------------------------------------------------------
module hht_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hht_in_if.sink        i_req,
    input  logic [1:0]    i_free,
    output hht_pkg::t_push o_push
);
    import hht_pkg::*;

    logic        r_in_valid;
    logic        r_action;
    logic [7:0]  r_byte;

    t_phase      r_phase, n_phase;
    logic        r_at_line_start, n_at_line_start;
    logic        r_cr_first, n_cr_first;
    logic        r_key_seen, n_key_seen;
    logic        r_value_seen, n_value_seen;
    logic        r_on_req_line, n_on_req_line;
    logic        r_header_done, n_header_done;
    logic        r_started, n_started;

    logic [1:0]  cnt;
    t_res        res_v [2];
    logic        ended;
    logic        ws;
    logic [7:0]  low_b;
    logic        proc;

    // The held request is processed once the queue has room for its results.
    assign proc        = r_in_valid && (cnt <= i_free);
    assign i_req.ready = !r_in_valid || proc;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_action <= i_req.action;
            r_byte   <= i_req.byte_in;
        end
    end

    // Tokenizer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= P_RL_SKIP0;
            r_at_line_start <= 1'b1;
            r_cr_first      <= 1'b0;
            r_key_seen      <= 1'b0;
            r_value_seen    <= 1'b0;
            r_on_req_line   <= 1'b1;
            r_header_done   <= 1'b0;
            r_started       <= 1'b0;
        end else if (proc) begin
            r_phase         <= n_phase;
            r_at_line_start <= n_at_line_start;
            r_cr_first      <= n_cr_first;
            r_key_seen      <= n_key_seen;
            r_value_seen    <= n_value_seen;
            r_on_req_line   <= n_on_req_line;
            r_header_done   <= n_header_done;
            r_started       <= n_started;
        end
    end

    assign ws    = is_ws(r_byte);
    assign low_b = (r_byte >= CH_UC_A && r_byte <= CH_UC_Z) ? r_byte + CASE_OFS : r_byte;

    // Step logic: next state and up to two result tokens for the held byte.
    always_comb begin
        n_phase         = r_phase;
        n_at_line_start = r_at_line_start;
        n_cr_first      = r_cr_first;
        n_key_seen      = r_key_seen;
        n_value_seen    = r_value_seen;
        n_on_req_line   = r_on_req_line;
        n_header_done   = r_header_done;
        n_started       = r_started;
        cnt             = 2'd0;
        res_v[0]        = '0;
        res_v[1]        = '0;
        ended           = 1'b0;

        if (r_action == ACT_RESTART) begin
            n_phase         = P_RL_SKIP0;
            n_at_line_start = 1'b1;
            n_cr_first      = 1'b0;
            n_key_seen      = 1'b0;
            n_value_seen    = 1'b0;
            n_on_req_line   = 1'b1;
            n_header_done   = 1'b0;
            n_started       = 1'b0;
        end else if (!r_header_done && r_byte != CH_NUL) begin
            // Line start: close the previous line unless this is a continuation.
            if (r_at_line_start) begin
                n_at_line_start = 1'b0;
                if (!(r_started && (r_byte == CH_SP || r_byte == CH_TAB))) begin
                    if (r_started) begin
                        res_v[cnt[0]] = mk_res(K_LINE_END, 8'h00,
                                               r_on_req_line || (r_key_seen && r_value_seen));
                        cnt           = cnt + 2'd1;
                        n_phase       = P_AT_SKIP;
                        n_on_req_line = 1'b0;
                        n_key_seen    = 1'b0;
                        n_value_seen  = 1'b0;
                    end
                    n_started = 1'b1;
                    if (r_byte == CH_LF) begin
                        res_v[cnt[0]] = mk_res(K_HDR_END, 8'h00, 1'b0);
                        cnt           = cnt + 2'd1;
                        n_header_done = 1'b1;
                        ended         = 1'b1;
                    end else begin
                        n_cr_first = (r_byte == CH_CR);
                    end
                end
            end else if (r_cr_first) begin
                // A line that began with CR is blank when LF follows.
                n_cr_first = 1'b0;
                if (r_byte == CH_LF) begin
                    res_v[cnt[0]] = mk_res(K_HDR_END, 8'h00, 1'b0);
                    cnt           = cnt + 2'd1;
                    n_header_done = 1'b1;
                    ended         = 1'b1;
                end
            end

            // Token scan within the current line.
            if (!ended) begin
                unique case (n_phase)
                    P_RL_SKIP0: begin
                        if (!ws) begin
                            res_v[cnt[0]] = mk_res(K_METHOD, r_byte, 1'b0);
                            cnt           = cnt + 2'd1;
                            n_phase       = P_METHOD;
                        end
                    end
                    P_METHOD: begin
                        if (ws) begin
                            n_phase = P_RL_SKIP1;
                        end else begin
                            res_v[cnt[0]] = mk_res(K_METHOD, r_byte, 1'b0);
                            cnt           = cnt + 2'd1;
                        end
                    end
                    P_RL_SKIP1: begin
                        if (!ws) begin
                            res_v[cnt[0]] = mk_res(K_URL, r_byte, 1'b0);
                            cnt           = cnt + 2'd1;
                            n_phase       = P_URL;
                        end
                    end
                    P_URL: begin
                        if (ws) begin
                            n_phase = P_RL_SKIP2;
                        end else begin
                            res_v[cnt[0]] = mk_res(K_URL, r_byte, 1'b0);
                            cnt           = cnt + 2'd1;
                        end
                    end
                    P_RL_SKIP2: begin
                        if (!ws) begin
                            res_v[cnt[0]] = mk_res(K_PROTO, r_byte, 1'b0);
                            cnt           = cnt + 2'd1;
                            n_phase       = P_PROTO;
                        end
                    end
                    P_PROTO: begin
                        if (ws) begin
                            n_phase = P_RL_TAIL;
                        end else begin
                            res_v[cnt[0]] = mk_res(K_PROTO, r_byte, 1'b0);
                            cnt           = cnt + 2'd1;
                        end
                    end
                    P_AT_SKIP, P_KEY: begin
                        if (ws && n_phase == P_AT_SKIP) begin
                            n_phase = P_AT_SKIP;
                        end else if (ws || r_byte == CH_COLON) begin
                            n_phase = P_AT_VSKIP;
                        end else begin
                            res_v[cnt[0]] = mk_res(K_KEY, low_b, 1'b0);
                            cnt           = cnt + 2'd1;
                            n_key_seen    = 1'b1;
                            n_phase       = P_KEY;
                        end
                    end
                    P_AT_VSKIP: begin
                        if (!ws) begin
                            n_phase       = P_VALUE;
                            res_v[cnt[0]] = mk_res(K_VALUE, r_byte, 1'b0);
                            cnt           = cnt + 2'd1;
                            n_value_seen  = 1'b1;
                        end
                    end
                    P_VALUE: begin
                        if (r_byte != CH_CR && r_byte != CH_LF) begin
                            res_v[cnt[0]] = mk_res(K_VALUE, r_byte, 1'b0);
                            cnt           = cnt + 2'd1;
                            n_value_seen  = 1'b1;
                        end
                    end
                    default: begin
                        // Trailing text of the request line is ignored.
                    end
                endcase
                if (r_byte == CH_LF) begin
                    n_at_line_start = 1'b1;
                end
            end

            // Mark the final token of this byte.
            if (cnt != 2'd0) begin
                res_v[1'(cnt - 2'd1)].last = 1'b1;
            end
        end
    end

    assign o_push.cnt  = proc ? cnt : 2'd0;
    assign o_push.res0 = res_v[0];
    assign o_push.res1 = res_v[1];

endmodule

// ===== rtl/hht_out_queue.sv =====
// ----------------------------------------------------------------------------
// HTTP header tokenizer output queue
// Two-slot shift queue that takes up to two tokens and drives the result channel.
// ----------------------------------------------------------------------------
module hht_out_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hht_pkg::t_push i_push,
    output logic [1:0]    o_free,
    hht_out_if.source     o_tok
);
    import hht_pkg::*;

    t_res        r_q [2];
    t_res        n_q [2];
    logic [1:0]  r_cnt, n_cnt;
    logic [1:0]  kept;
    logic        pop;

    assign pop    = (r_cnt != 2'd0) && o_tok.ready;
    assign kept   = r_cnt - {1'b0, pop};
    assign o_free = 2'd2 - kept;

    // Shift out the head on a pop, then append the new tokens behind.
    always_comb begin
        n_q[0] = r_q[0];
        n_q[1] = r_q[1];
        if (pop) begin
            n_q[0] = r_q[1];
        end
        if (i_push.cnt != 2'd0) begin
            n_q[kept[0]] = i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            n_q[1] = i_push.res1;
        end
        n_cnt = kept + i_push.cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

    assign o_tok.valid = (r_cnt != 2'd0);
    assign o_tok.kind  = r_q[0].kind;
    assign o_tok.data  = r_q[0].data;
    assign o_tok.keep  = r_q[0].keep;
    assign o_tok.last  = r_q[0].last;

endmodule
